// File: sv/lavm_pkg.sv
// Shared types, constants and rounding helper for the look-at view matrix block.
package lavm_pkg;

  localparam int MAG_W  = 30;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int NUM_W  = 61;
  localparam int QUOT_W = 31;

  localparam logic [5:0] LEAD_POS = 6'(MAG_W - 1);

  localparam logic signed [31:0] UP_X_RESET = 32'sd0;
  localparam logic signed [31:0] UP_Y_RESET = 32'sd65536;
  localparam logic signed [31:0] UP_Z_RESET = 32'sd0;

  localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;
  localparam logic signed [65:0] SAT_HI   = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO   = -66'sd2147483648;

  typedef enum logic [1:0] {
    REG_UP_X = 2'd0,
    REG_UP_Y = 2'd1,
    REG_UP_Z = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } out_item_t;

  typedef logic [2:0][63:0] nin_t;
  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    vec_t zv;
    vec_t eye;
  } side_t;

  function automatic logic signed [31:0] round_sat(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = (v + HALF_Q30) >>> 30;
    if (s > SAT_HI) begin
      round_sat = 32'sh7fffffff;
    end else if (s < SAT_LO) begin
      round_sat = 32'sh80000000;
    end else begin
      round_sat = s[31:0];
    end
  endfunction

endpackage

// File: sv/look_at_view_matrix.sv
// Top level of the look-at view matrix block.
//
// Each input transaction carries an eye position and a target point in Q16.16.
// The up vector comes from three configuration registers written through
// cfg_write, cfg_index and cfg_data; write them only while no transaction is
// in flight. One output transaction carries the right, upward and back axes in
// Q1.30 and the three saturated translation terms in Q16.16.
// The pipeline accepts one transaction per cycle while the receiver does not
// stall. Each of the two normalizers spends 31 stages on the square root and
// 31 stages on the divisions, one result bit per stage.
// Reset clears every valid bit and loads the up vector with (0, 1, 0).
// When the receiver stalls while a result is waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Bubbles are not squeezed out during a stall.
module look_at_view_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lavm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lavm_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic               en;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  logic               t0_valid;
  lavm_pkg::nin_t     t0_d;
  lavm_pkg::side_t    t0_side;

  logic               n1_valid;
  lavm_pkg::vec_t     n1_vec;
  lavm_pkg::side_t    n1_side;

  logic               t1_valid;
  logic signed [63:0] t1_prod [0:5];
  lavm_pkg::side_t    t1_side;

  logic               t2_valid;
  lavm_pkg::nin_t     t2_c;
  lavm_pkg::side_t    t2_side;

  logic               n2_valid;
  lavm_pkg::vec_t     n2_vec;
  lavm_pkg::side_t    n2_side;

  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_x <= lavm_pkg::UP_X_RESET;
      up_y <= lavm_pkg::UP_Y_RESET;
      up_z <= lavm_pkg::UP_Z_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lavm_pkg::REG_UP_X: up_x <= cfg_data;
        lavm_pkg::REG_UP_Y: up_y <= cfg_data;
        lavm_pkg::REG_UP_Z: up_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid <= 1'b0;
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
    end else if (en) begin
      t0_valid <= in_valid;
      t1_valid <= n1_valid;
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d[0] <= 64'(in_data.eye_x) - 64'(in_data.aim_x);
      t0_d[1] <= 64'(in_data.eye_y) - 64'(in_data.aim_y);
      t0_d[2] <= 64'(in_data.eye_z) - 64'(in_data.aim_z);
      t0_side.zv     <= '0;
      t0_side.eye[0] <= in_data.eye_x;
      t0_side.eye[1] <= in_data.eye_y;
      t0_side.eye[2] <= in_data.eye_z;

      t1_prod[0] <= up_y * $signed(n1_vec[2]);
      t1_prod[1] <= up_z * $signed(n1_vec[1]);
      t1_prod[2] <= up_z * $signed(n1_vec[0]);
      t1_prod[3] <= up_x * $signed(n1_vec[2]);
      t1_prod[4] <= up_x * $signed(n1_vec[1]);
      t1_prod[5] <= up_y * $signed(n1_vec[0]);
      t1_side.zv  <= n1_vec;
      t1_side.eye <= n1_side.eye;

      t2_c[0] <= t1_prod[0] - t1_prod[1];
      t2_c[1] <= t1_prod[2] - t1_prod[3];
      t2_c[2] <= t1_prod[4] - t1_prod[5];
      t2_side <= t1_side;
    end
  end

  lavm_norm u_norm_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t0_valid),
    .in_vec    (t0_d),
    .in_side   (t0_side),
    .out_valid (n1_valid),
    .out_vec   (n1_vec),
    .out_side  (n1_side)
  );

  lavm_norm u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t2_valid),
    .in_vec    (t2_c),
    .in_side   (t2_side),
    .out_valid (n2_valid),
    .out_vec   (n2_vec),
    .out_side  (n2_side)
  );

  lavm_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n2_valid),
    .in_x      (n2_vec),
    .in_side   (n2_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sv/lavm_norm.sv
// Pipelined three-component vector normalizer with bit-serial square root and division.
module lavm_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  lavm_pkg::nin_t  in_vec,
  input  lavm_pkg::side_t in_side,
  output logic            out_valid,
  output lavm_pkg::vec_t  out_vec,
  output lavm_pkg::side_t out_side
);

  logic                   a_valid;
  logic [2:0][62:0]       a_abs;
  logic [2:0]             a_neg;
  logic [63:0]            a_or;
  lavm_pkg::side_t        a_side;
  logic [2:0][62:0]       abs_in;

  logic                   b_valid;
  logic [2:0][62:0]       b_abs;
  logic [2:0]             b_neg;
  lavm_pkg::side_t        b_side;
  logic [7:0]             b_any;
  logic [7:0][2:0]        b_pos;
  logic [7:0]             grp_any;
  logic [7:0][2:0]        grp_pos;

  logic                   l_valid;
  logic [2:0][62:0]       l_abs;
  logic [2:0]             l_neg;
  lavm_pkg::side_t        l_side;
  logic [5:0]             l_lead;
  logic                   l_zero;
  logic [5:0]             lead;

  logic                   m_valid;
  logic [2:0][lavm_pkg::MAG_W-1:0] m_a;
  logic [2:0]             m_neg;
  lavm_pkg::side_t        m_side;
  logic                   m_zero;
  logic [2:0][lavm_pkg::MAG_W-1:0] scaled;
  logic [2:0][62:0]       wide_sh;

  logic                   q_valid;
  logic [2:0][lavm_pkg::MAG_W-1:0] q_a;
  logic [2:0][2*lavm_pkg::MAG_W-1:0] q_sq;
  logic [2:0]             q_neg;
  lavm_pkg::side_t        q_side;
  logic                   q_zero;

  logic                          s_valid [0:lavm_pkg::ROOT_W];
  logic [lavm_pkg::SUM_W-1:0]    s_rem   [0:lavm_pkg::ROOT_W];
  logic [lavm_pkg::ROOT_W-1:0]   s_root  [0:lavm_pkg::ROOT_W];
  logic [2:0][lavm_pkg::MAG_W-1:0] s_a   [0:lavm_pkg::ROOT_W];
  logic [2:0]                    s_neg   [0:lavm_pkg::ROOT_W];
  logic                          s_zero  [0:lavm_pkg::ROOT_W];
  lavm_pkg::side_t               s_side  [0:lavm_pkg::ROOT_W];
  logic [lavm_pkg::SUM_W-1:0]    s_rem_next  [0:lavm_pkg::ROOT_W-1];
  logic [lavm_pkg::ROOT_W-1:0]   s_root_next [0:lavm_pkg::ROOT_W-1];

  logic                          dv_valid [0:lavm_pkg::QUOT_W];
  logic [2:0][lavm_pkg::NUM_W-1:0]  dv_rem [0:lavm_pkg::QUOT_W];
  logic [2:0][lavm_pkg::QUOT_W-1:0] dv_q   [0:lavm_pkg::QUOT_W];
  logic [lavm_pkg::ROOT_W-1:0]   dv_r     [0:lavm_pkg::QUOT_W];
  logic [2:0]                    dv_neg   [0:lavm_pkg::QUOT_W];
  logic                          dv_zero  [0:lavm_pkg::QUOT_W];
  lavm_pkg::side_t               dv_side  [0:lavm_pkg::QUOT_W];
  logic [2:0][lavm_pkg::NUM_W-1:0]  dv_rem_next [0:lavm_pkg::QUOT_W-1];
  logic [2:0][lavm_pkg::QUOT_W-1:0] dv_q_next   [0:lavm_pkg::QUOT_W-1];

  logic [2:0][lavm_pkg::NUM_W-1:0] numer;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_in[i] = in_vec[i][63] ? 63'(-in_vec[i]) : in_vec[i][62:0];
    end
  end

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_any[g] = |a_or[8*g +: 8];
      grp_pos[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (a_or[8*g+b]) begin
          grp_pos[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    lead = '0;
    for (int g = 0; g < 8; g++) begin
      if (b_any[g]) begin
        lead = {3'(g), b_pos[g]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (l_lead >= lavm_pkg::LEAD_POS) begin
        wide_sh[i] = l_abs[i] >> (l_lead - lavm_pkg::LEAD_POS);
      end else begin
        wide_sh[i] = l_abs[i] << (lavm_pkg::LEAD_POS - l_lead);
      end
      scaled[i] = wide_sh[i][lavm_pkg::MAG_W-1:0];
    end
  end

  // One root bit per stage, most significant first.
  always_comb begin
    for (int k = 0; k < lavm_pkg::ROOT_W; k++) begin
      logic [62:0] trial;
      logic [62:0] remx;
      trial = (63'(s_root[k]) << (lavm_pkg::ROOT_W - k)) +
              (63'(1) << (2 * (lavm_pkg::ROOT_W - 1 - k)));
      remx = {1'b0, s_rem[k]};
      if (remx >= trial) begin
        s_rem_next[k]  = lavm_pkg::SUM_W'(remx - trial);
        s_root_next[k] = s_root[k] | (lavm_pkg::ROOT_W'(1) << (lavm_pkg::ROOT_W - 1 - k));
      end else begin
        s_rem_next[k]  = s_rem[k];
        s_root_next[k] = s_root[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = {1'b0, s_a[lavm_pkg::ROOT_W][i], 30'b0} +
                 lavm_pkg::NUM_W'(s_root[lavm_pkg::ROOT_W] >> 1);
    end
  end

  // One quotient bit per stage for all three components.
  always_comb begin
    for (int k = 0; k < lavm_pkg::QUOT_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        logic [lavm_pkg::NUM_W-1:0] dvs;
        dvs = lavm_pkg::NUM_W'(dv_r[k]) << (lavm_pkg::QUOT_W - 1 - k);
        if (dv_rem[k][i] >= dvs) begin
          dv_rem_next[k][i] = dv_rem[k][i] - dvs;
          dv_q_next[k][i]   = dv_q[k][i] |
                              (lavm_pkg::QUOT_W'(1) << (lavm_pkg::QUOT_W - 1 - k));
        end else begin
          dv_rem_next[k][i] = dv_rem[k][i];
          dv_q_next[k][i]   = dv_q[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      l_valid   <= 1'b0;
      m_valid   <= 1'b0;
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= lavm_pkg::ROOT_W; k++) begin
        s_valid[k] <= 1'b0;
      end
      for (int k = 0; k <= lavm_pkg::QUOT_W; k++) begin
        dv_valid[k] <= 1'b0;
      end
    end else if (en) begin
      a_valid    <= in_valid;
      b_valid    <= a_valid;
      l_valid    <= b_valid;
      m_valid    <= l_valid;
      q_valid    <= m_valid;
      s_valid[0] <= q_valid;
      for (int k = 0; k < lavm_pkg::ROOT_W; k++) begin
        s_valid[k+1] <= s_valid[k];
      end
      dv_valid[0] <= s_valid[lavm_pkg::ROOT_W];
      for (int k = 0; k < lavm_pkg::QUOT_W; k++) begin
        dv_valid[k+1] <= dv_valid[k];
      end
      out_valid <= dv_valid[lavm_pkg::QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_abs  <= abs_in;
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_vec[i][63];
      end
      a_or   <= {1'b0, abs_in[0] | abs_in[1] | abs_in[2]};
      a_side <= in_side;

      b_abs  <= a_abs;
      b_neg  <= a_neg;
      b_side <= a_side;
      b_any  <= grp_any;
      b_pos  <= grp_pos;

      l_abs  <= b_abs;
      l_neg  <= b_neg;
      l_side <= b_side;
      l_lead <= lead;
      l_zero <= ~|b_any;

      m_a    <= scaled;
      m_neg  <= l_neg;
      m_side <= l_side;
      m_zero <= l_zero;

      for (int i = 0; i < 3; i++) begin
        q_sq[i] <= m_a[i] * m_a[i];
      end
      q_a    <= m_a;
      q_neg  <= m_neg;
      q_side <= m_side;
      q_zero <= m_zero;

      s_rem[0]  <= lavm_pkg::SUM_W'(q_sq[0]) + lavm_pkg::SUM_W'(q_sq[1]) +
                   lavm_pkg::SUM_W'(q_sq[2]);
      s_root[0] <= '0;
      s_a[0]    <= q_a;
      s_neg[0]  <= q_neg;
      s_zero[0] <= q_zero;
      s_side[0] <= q_side;
      for (int k = 0; k < lavm_pkg::ROOT_W; k++) begin
        s_rem[k+1]  <= s_rem_next[k];
        s_root[k+1] <= s_root_next[k];
        s_a[k+1]    <= s_a[k];
        s_neg[k+1]  <= s_neg[k];
        s_zero[k+1] <= s_zero[k];
        s_side[k+1] <= s_side[k];
      end

      dv_rem[0]  <= numer;
      dv_q[0]    <= '0;
      dv_r[0]    <= s_root[lavm_pkg::ROOT_W];
      dv_neg[0]  <= s_neg[lavm_pkg::ROOT_W];
      dv_zero[0] <= s_zero[lavm_pkg::ROOT_W];
      dv_side[0] <= s_side[lavm_pkg::ROOT_W];
      for (int k = 0; k < lavm_pkg::QUOT_W; k++) begin
        dv_rem[k+1]  <= dv_rem_next[k];
        dv_q[k+1]    <= dv_q_next[k];
        dv_r[k+1]    <= dv_r[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_side[k+1] <= dv_side[k];
      end

      for (int i = 0; i < 3; i++) begin
        if (dv_zero[lavm_pkg::QUOT_W]) begin
          out_vec[i] <= '0;
        end else if (dv_neg[lavm_pkg::QUOT_W][i]) begin
          out_vec[i] <= -{1'b0, dv_q[lavm_pkg::QUOT_W][i]};
        end else begin
          out_vec[i] <= {1'b0, dv_q[lavm_pkg::QUOT_W][i]};
        end
      end
      out_side <= dv_side[lavm_pkg::QUOT_W];
    end
  end

endmodule

// File: sv/lavm_finish.sv
// Pipelined upward axis and translation stages that form the result transaction.
module lavm_finish (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  lavm_pkg::vec_t      in_x,
  input  lavm_pkg::side_t     in_side,
  output logic                out_valid,
  output lavm_pkg::out_item_t out_data
);

  logic                 p1_valid;
  logic signed [63:0]   p1_zx [0:5];
  logic signed [63:0]   p1_xe [0:2];
  logic signed [63:0]   p1_ze [0:2];
  lavm_pkg::vec_t       p1_x;
  lavm_pkg::vec_t       p1_z;
  lavm_pkg::vec_t       p1_e;

  logic                 p2_valid;
  lavm_pkg::vec_t       p2_x;
  lavm_pkg::vec_t       p2_y;
  lavm_pkg::vec_t       p2_z;
  lavm_pkg::vec_t       p2_e;
  logic signed [31:0]   p2_sx;
  logic signed [31:0]   p2_sz;

  logic                 p3_valid;
  logic signed [63:0]   p3_ye [0:2];
  lavm_pkg::vec_t       p3_x;
  lavm_pkg::vec_t       p3_y;
  lavm_pkg::vec_t       p3_z;
  logic signed [31:0]   p3_sx;
  logic signed [31:0]   p3_sz;

  logic signed [65:0]   dot_x;
  logic signed [65:0]   dot_z;
  logic signed [65:0]   dot_y;

  assign dot_x = 66'(p1_xe[0]) + 66'(p1_xe[1]) + 66'(p1_xe[2]);
  assign dot_z = 66'(p1_ze[0]) + 66'(p1_ze[1]) + 66'(p1_ze[2]);
  assign dot_y = 66'(p3_ye[0]) + 66'(p3_ye[1]) + 66'(p3_ye[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= in_valid;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_zx[0] <= $signed(in_side.zv[1]) * $signed(in_x[2]);
      p1_zx[1] <= $signed(in_side.zv[2]) * $signed(in_x[1]);
      p1_zx[2] <= $signed(in_side.zv[2]) * $signed(in_x[0]);
      p1_zx[3] <= $signed(in_side.zv[0]) * $signed(in_x[2]);
      p1_zx[4] <= $signed(in_side.zv[0]) * $signed(in_x[1]);
      p1_zx[5] <= $signed(in_side.zv[1]) * $signed(in_x[0]);
      for (int i = 0; i < 3; i++) begin
        p1_xe[i] <= $signed(in_x[i]) * $signed(in_side.eye[i]);
        p1_ze[i] <= $signed(in_side.zv[i]) * $signed(in_side.eye[i]);
      end
      p1_x <= in_x;
      p1_z <= in_side.zv;
      p1_e <= in_side.eye;

      p2_y[0] <= lavm_pkg::round_sat(66'(p1_zx[0] - p1_zx[1]));
      p2_y[1] <= lavm_pkg::round_sat(66'(p1_zx[2] - p1_zx[3]));
      p2_y[2] <= lavm_pkg::round_sat(66'(p1_zx[4] - p1_zx[5]));
      p2_sx   <= lavm_pkg::round_sat(-dot_x);
      p2_sz   <= lavm_pkg::round_sat(-dot_z);
      p2_x    <= p1_x;
      p2_z    <= p1_z;
      p2_e    <= p1_e;

      for (int i = 0; i < 3; i++) begin
        p3_ye[i] <= $signed(p2_y[i]) * $signed(p2_e[i]);
      end
      p3_x  <= p2_x;
      p3_y  <= p2_y;
      p3_z  <= p2_z;
      p3_sx <= p2_sx;
      p3_sz <= p2_sz;

      out_data.right_x  <= p3_x[0];
      out_data.right_y  <= p3_x[1];
      out_data.right_z  <= p3_x[2];
      out_data.upward_x <= p3_y[0];
      out_data.upward_y <= p3_y[1];
      out_data.upward_z <= p3_y[2];
      out_data.back_x   <= p3_z[0];
      out_data.back_y   <= p3_z[1];
      out_data.back_z   <= p3_z[2];
      out_data.shift_x  <= p3_sx;
      out_data.shift_y  <= lavm_pkg::round_sat(-dot_y);
      out_data.shift_z  <= p3_sz;
    end
  end

endmodule
